FILE: sv/cibc_pkg.sv
package cibc_pkg;

  // Image geometry
  localparam int MAX_COMPONENTS = 3;
  localparam int BLOCK_COEFFS   = 64;
  localparam int POS_W          = $clog2(BLOCK_COEFFS);
  localparam int COMP_W         = 2;
  localparam int ROW_W          = 13;
  localparam int WID_W          = 14;
  localparam int COEF_W         = 33;
  localparam int IDX_W          = 34;
  localparam int TOT_W          = 34;
  localparam int BLK_W          = COEF_W - POS_W;
  localparam int MAX_WIDTH      = 1 << ROW_W;
  localparam int STAT_W         = 2;

  // Stream payload widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = ((IDX_W + 7) / 8) * 8;
  localparam int OUT_BITS    = COMP_W + 2 * ROW_W + POS_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Register port
  localparam int REG_COUNT_N = 8;
  localparam int REG_SHIFT   = 3;
  localparam int APB_DW      = 64;
  localparam int APB_AW      = $clog2(REG_COUNT_N) + REG_SHIFT;

  // Reset values
  localparam logic [COMP_W-1:0] RST_COUNT  = COMP_W'(3);
  localparam logic [WID_W-1:0]  RST_WIDTH  = WID_W'(1);
  localparam logic [COEF_W-1:0] RST_COEFFS = COEF_W'(64);
  localparam logic [TOT_W-1:0]  RST_TOTAL  = TOT_W'(192);

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_SIZE  = 2'd2
  } status_t;

  typedef enum logic [APB_AW-REG_SHIFT-1:0] {
    REG_COUNT    = 3'd0,
    REG_WIDTH_0  = 3'd1,
    REG_WIDTH_1  = 3'd2,
    REG_WIDTH_2  = 3'd3,
    REG_COEFFS_0 = 3'd4,
    REG_COEFFS_1 = 3'd5,
    REG_COEFFS_2 = 3'd6,
    REG_TOTAL    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [COMP_W-1:0]                      count;
    logic [MAX_COMPONENTS-1:0][WID_W-1:0]   width;
    logic [MAX_COMPONENTS-1:0][COEF_W-1:0]  coeffs;
    logic [TOT_W-1:0]                       total;
  } cfg_t;

  // Item while the owning component is searched for
  typedef struct packed {
    status_t            status;
    logic               found;
    logic [COMP_W-1:0]  comp;
    logic [IDX_W-1:0]   rest;
  } seek_t;

  // Item while the block number is divided by the width
  typedef struct packed {
    status_t            status;
    logic [COMP_W-1:0]  comp;
    logic [POS_W-1:0]   pos;
    logic [BLK_W-1:0]   rem;
    logic [ROW_W-1:0]   quo;
    logic [BLK_W-1:0]   dvs;
  } div_t;

  function automatic logic [COEF_W-1:0] coeffs_of(cfg_t cfg, logic [COMP_W-1:0] comp);
    logic [COEF_W-1:0] val;
    val = '0;
    if (comp < COMP_W'(MAX_COMPONENTS)) begin
      val = cfg.coeffs[comp];
    end
    return val;
  endfunction

  function automatic logic [WID_W-1:0] width_of(cfg_t cfg, logic [COMP_W-1:0] comp);
    logic [WID_W-1:0] val;
    val = '0;
    if (comp < COMP_W'(MAX_COMPONENTS)) begin
      val = cfg.width[comp];
    end
    return val;
  endfunction

endpackage

FILE: sv/coefficient_index_to_block_coords_core.sv
// Channel  Dir  Transfer when              Payload
// s_*      in   s_tvalid & s_tready        flat_index
// m_*      out  m_tvalid & m_tready        component, block_row, block_col, coeff_pos; status
// APB      in   psel & penable & pwrite    eight registers at byte address 8*i, 64-bit data
//
// One flat index enters per cycle while s_tready is high; its result passes the entry
// register, three component-search stages, a select stage, 13 quotient stages and the
// output register. The 13-stage restoring divider computes block number / width.
// rst is synchronous and active high; it empties every stage and loads the register
// reset values. Each stage holds only while it is full and the stage after it is
// blocked, so a stall on m_* fills bubbles first and s_tready drops only once the
// whole pipe is full.
module coefficient_index_to_block_coords_core import cibc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // flat_index [33:0], zero pad above
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // component [1:0], block_row [14:2], block_col [27:15], coeff_pos [33:28], zero pad above
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // status [1:0]
  output logic [STAT_W-1:0]      m_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  cfg_t cfg;

  cibc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage index 0 is the entry register; 1..MAX_COMPONENTS are search stages.
  // Each load array carries one extra slot for the stage that follows the chain.
  seek_t seek_item  [MAX_COMPONENTS+1];
  logic  seek_valid [MAX_COMPONENTS+1];
  logic  seek_load  [MAX_COMPONENTS+2];

  // Stage index 0 is the select register; 1..ROW_W are quotient stages.
  div_t  div_item   [ROW_W+1];
  logic  div_valid  [ROW_W+1];
  logic  div_load   [ROW_W+2];

  logic  out_load;
  seek_t entry_next;
  div_t  sel_next;

  // ---------------------------------------------------------------- entry
  // Flag an index at or above the total before the search starts.
  assign seek_load[0] = !seek_valid[0] || seek_load[1];
  assign s_tready     = seek_load[0];

  always_comb begin
    entry_next.rest   = s_tdata[IDX_W-1:0];
    entry_next.found  = 1'b0;
    entry_next.comp   = '0;
    entry_next.status = (s_tdata[IDX_W-1:0] >= cfg.total) ? STATUS_RANGE : STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seek_valid[0] <= 1'b0;
    end else if (seek_load[0]) begin
      seek_valid[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (seek_load[0]) begin
      seek_item[0] <= entry_next;
    end
  end

  // ------------------------------------------------------ component search
  // One component per stage: claim it or subtract its count.
  assign seek_load[MAX_COMPONENTS+1] = div_load[0];

  for (genvar k = 1; k <= MAX_COMPONENTS; k++) begin : g_seek
    cibc_seek u_seek (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cfg),
      .in_valid  (seek_valid[k-1]),
      .in_ready  (seek_load[k]),
      .in_item   (seek_item[k-1]),
      .out_valid (seek_valid[k]),
      .out_ready (seek_load[k+1]),
      .out_item  (seek_item[k])
    );
  end

  // ---------------------------------------------------------------- select
  // Split off the position, check the width and the row bound, and set up
  // the divisor as width shifted to the top quotient bit.
  logic [WID_W-1:0] sel_width;
  logic [BLK_W-1:0] sel_block;

  assign div_load[0] = !div_valid[0] || div_load[1];
  assign sel_width   = width_of(cfg, seek_item[MAX_COMPONENTS].comp);
  assign sel_block   = seek_item[MAX_COMPONENTS].rest[COEF_W-1:POS_W];

  always_comb begin
    sel_next.status = seek_item[MAX_COMPONENTS].status;
    sel_next.comp   = seek_item[MAX_COMPONENTS].comp;
    sel_next.pos    = seek_item[MAX_COMPONENTS].rest[POS_W-1:0];
    sel_next.rem    = sel_block;
    sel_next.quo    = '0;
    sel_next.dvs    = BLK_W'(sel_width) << (ROW_W - 1);
    if (seek_item[MAX_COMPONENTS].status == STATUS_OK) begin
      // past every component in use, bad width, or row beyond the limit
      if (!seek_item[MAX_COMPONENTS].found || sel_width == '0 ||
          sel_width > WID_W'(MAX_WIDTH) ||
          sel_block >= (BLK_W'(sel_width) << ROW_W)) begin
        sel_next.status = STATUS_SIZE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_valid[0] <= 1'b0;
    end else if (div_load[0]) begin
      div_valid[0] <= seek_valid[MAX_COMPONENTS];
    end
  end

  always_ff @(posedge clk) begin
    if (div_load[0]) begin
      div_item[0] <= sel_next;
    end
  end

  // ------------------------------------------------------------- divider
  // One quotient bit per stage, most significant first; the remainder left
  // after the last stage is the block column.
  assign div_load[ROW_W+1] = out_load;

  for (genvar j = 1; j <= ROW_W; j++) begin : g_div
    cibc_div u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (div_valid[j-1]),
      .in_ready  (div_load[j]),
      .in_item   (div_item[j-1]),
      .out_valid (div_valid[j]),
      .out_ready (div_load[j+1]),
      .out_item  (div_item[j])
    );
  end

  // -------------------------------------------------------------- output
  // Zero the coordinates of an error result.
  logic [COMP_W-1:0] out_comp;
  logic [ROW_W-1:0]  out_row;
  logic [ROW_W-1:0]  out_col;
  logic [POS_W-1:0]  out_pos;
  status_t           out_status;
  logic              fin_ok;

  assign out_load = !m_tvalid || m_tready;
  assign fin_ok   = div_item[ROW_W].status == STATUS_OK;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= div_valid[ROW_W];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= div_item[ROW_W].status;
      out_comp   <= fin_ok ? div_item[ROW_W].comp : '0;
      out_row    <= fin_ok ? div_item[ROW_W].quo : '0;
      out_col    <= fin_ok ? div_item[ROW_W].rem[ROW_W-1:0] : '0;
      out_pos    <= fin_ok ? div_item[ROW_W].pos : '0;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - OUT_BITS)'(0), out_pos, out_col, out_row, out_comp};
  assign m_tuser = out_status;

endmodule

FILE: sv/cibc_cfg.sv
module cibc_cfg import cibc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:REG_SHIFT]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count  <= RST_COUNT;
      cfg.width  <= {MAX_COMPONENTS{RST_WIDTH}};
      cfg.coeffs <= {MAX_COMPONENTS{RST_COEFFS}};
      cfg.total  <= RST_TOTAL;
    end else if (wr) begin
      unique case (idx)
        REG_COUNT:    cfg.count     <= pwdata[COMP_W-1:0];
        REG_WIDTH_0:  cfg.width[0]  <= pwdata[WID_W-1:0];
        REG_WIDTH_1:  cfg.width[1]  <= pwdata[WID_W-1:0];
        REG_WIDTH_2:  cfg.width[2]  <= pwdata[WID_W-1:0];
        REG_COEFFS_0: cfg.coeffs[0] <= pwdata[COEF_W-1:0];
        REG_COEFFS_1: cfg.coeffs[1] <= pwdata[COEF_W-1:0];
        REG_COEFFS_2: cfg.coeffs[2] <= pwdata[COEF_W-1:0];
        REG_TOTAL:    cfg.total     <= pwdata[TOT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_COUNT:    prdata = APB_DW'(cfg.count);
      REG_WIDTH_0:  prdata = APB_DW'(cfg.width[0]);
      REG_WIDTH_1:  prdata = APB_DW'(cfg.width[1]);
      REG_WIDTH_2:  prdata = APB_DW'(cfg.width[2]);
      REG_COEFFS_0: prdata = APB_DW'(cfg.coeffs[0]);
      REG_COEFFS_1: prdata = APB_DW'(cfg.coeffs[1]);
      REG_COEFFS_2: prdata = APB_DW'(cfg.coeffs[2]);
      REG_TOTAL:    prdata = APB_DW'(cfg.total);
    endcase
  end

endmodule

FILE: sv/cibc_seek.sv
module cibc_seek import cibc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  seek_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output seek_t out_item
);

  seek_t             item_next;
  logic [COEF_W-1:0] coeff;

  assign in_ready = !out_valid || out_ready;
  assign coeff    = coeffs_of(cfg, in_item.comp);

  // Claim the item for this component, or step past it
  always_comb begin
    item_next = in_item;
    if (in_item.status == STATUS_OK && !in_item.found) begin
      if ((in_item.comp < cfg.count) && (in_item.rest < IDX_W'(coeff))) begin
        item_next.found = 1'b1;
      end else begin
        item_next.rest = in_item.rest - IDX_W'(coeff);
        item_next.comp = in_item.comp + COMP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_item <= item_next;
    end
  end

endmodule

FILE: sv/cibc_div.sv
module cibc_div import cibc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_item
);

  div_t item_next;
  logic take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_item.rem >= in_item.dvs;

  // One restoring quotient bit
  always_comb begin
    item_next     = in_item;
    item_next.rem = take ? in_item.rem - in_item.dvs : in_item.rem;
    item_next.quo = {in_item.quo[ROW_W-2:0], take};
    item_next.dvs = in_item.dvs >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_item <= item_next;
    end
  end

endmodule

FILE: sv/cibc_checker.sv
module cibc_checker import cibc_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [STAT_W-1:0]      m_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready
);

  // A blocked result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // An error result carries no coordinates
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != STATUS_OK |-> m_tdata == '0)
    else $error("error result with non-zero coordinates");

  // Status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == STATUS_OK || m_tuser == STATUS_RANGE ||
                  m_tuser == STATUS_SIZE))
    else $error("undefined status code");

  // A good result names a component that exists
  a_comp_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == STATUS_OK |-> m_tdata[COMP_W-1:0] < COMP_W'(MAX_COMPONENTS))
    else $error("component out of range");

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid straight after reset");

endmodule

bind coefficient_index_to_block_coords_core cibc_checker u_cibc_checker (.*);

FILE: dv/testbench.sv
`default_nettype none

module testbench;
  import cibc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One result as the block hands it back: fields in the order of the tdata packing
  typedef struct packed {
    logic [COMP_W-1:0] component;
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  col;
    logic [POS_W-1:0]  pos;
    status_t           status;
  } coord_t;

  typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;

  // A directed row is either a register write or one flat index. Where typed is set the
  // expected coordinates are given in the row; otherwise the predictor supplies them.
  typedef struct packed {
    row_kind_t        kind;
    reg_idx_t         regno;
    logic [63:0]      value;
    logic [IDX_W-1:0] index;
    bit               typed;
    coord_t           want;
  } stim_row_t;

  typedef enum int {SET_SMALL, SET_WIDE, SET_BROKEN, SET_EXTREME} setting_t;

  localparam coord_t C_RANGE = '{2'd0, 13'd0, 13'd0, 6'd0, STATUS_RANGE};
  localparam coord_t C_SIZE  = '{2'd0, 13'd0, 13'd0, 6'd0, STATUS_SIZE};
  localparam coord_t C_ANY   = '{2'd0, 13'd0, 13'd0, 6'd0, STATUS_OK};

  localparam int DIRECTED_ROWS = 35;

  // Walk the reset setting first (three components of a single block each), then the
  // error paths, the component of maximum width and size, a 3-wide one, an empty total.
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'd0,   1'b1, '{2'd0, 13'd0, 13'd0, 6'd0,  STATUS_OK}},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'd63,  1'b1, '{2'd0, 13'd0, 13'd0, 6'd63, STATUS_OK}},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'd64,  1'b1, '{2'd1, 13'd0, 13'd0, 6'd0,  STATUS_OK}},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'd191, 1'b1, '{2'd2, 13'd0, 13'd0, 6'd63, STATUS_OK}},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'd192, 1'b1, C_RANGE},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'h3_FFFF_FFFF, 1'b1, C_RANGE},
    // no component in use: everything below the total is inconsistent
    '{ROW_WRITE, REG_COUNT, 64'd0, 34'd0,   1'b0, C_ANY},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'd0,   1'b1, C_SIZE},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'd191, 1'b1, C_SIZE},
    // two components, total still covering three: index past all components
    '{ROW_WRITE, REG_COUNT, 64'd2, 34'd0,   1'b0, C_ANY},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'd127, 1'b1, '{2'd1, 13'd0, 13'd0, 6'd63, STATUS_OK}},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'd128, 1'b1, C_SIZE},
    // upper write data bits must be dropped
    '{ROW_WRITE, REG_COUNT, 64'hFFFF_FFFF_FFFF_FFFF, 34'd0, 1'b0, C_ANY},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'd130, 1'b1, '{2'd2, 13'd0, 13'd0, 6'd2, STATUS_OK}},
    // bad widths: zero and above the maximum
    '{ROW_WRITE, REG_WIDTH_0, 64'd0, 34'd0, 1'b0, C_ANY},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'd5,   1'b1, C_SIZE},
    '{ROW_WRITE, REG_WIDTH_0, 64'h3FFF, 34'd0, 1'b0, C_ANY},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'd5,   1'b1, C_SIZE},
    // widest component with the largest count: last row, row overflow beyond it
    '{ROW_WRITE, REG_WIDTH_0,  64'd8192,        34'd0, 1'b0, C_ANY},
    '{ROW_WRITE, REG_COEFFS_0, 64'h1_FFFF_FFFF, 34'd0, 1'b0, C_ANY},
    '{ROW_WRITE, REG_TOTAL,    64'h3_FFFF_FFFF, 34'd0, 1'b0, C_ANY},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'd0,      1'b1, '{2'd0, 13'd0, 13'd0, 6'd0, STATUS_OK}},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'd524287, 1'b1,
      '{2'd0, 13'd0, 13'd8191, 6'd63, STATUS_OK}},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'h0_FFFF_FFFF, 1'b1,
      '{2'd0, 13'd8191, 13'd8191, 6'd63, STATUS_OK}},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'h1_0000_0000, 1'b1, C_SIZE},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'h1_FFFF_FFFE, 1'b1, C_SIZE},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'h1_FFFF_FFFF, 1'b1,
      '{2'd1, 13'd0, 13'd0, 6'd0, STATUS_OK}},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'h2_0000_007E, 1'b1,
      '{2'd2, 13'd0, 13'd0, 6'd63, STATUS_OK}},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'h2_0000_007F, 1'b1, C_SIZE},
    // component 1 becomes 3 blocks wide and 5 high
    '{ROW_WRITE, REG_WIDTH_1,  64'd3,   34'd0, 1'b0, C_ANY},
    '{ROW_WRITE, REG_COEFFS_1, 64'd960, 34'd0, 1'b0, C_ANY},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'h2_0000_00C7, 1'b0, C_ANY},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'h2_0000_03BE, 1'b0, C_ANY},
    // empty total: every index is out of range
    '{ROW_WRITE, REG_TOTAL, 64'd0, 34'd0, 1'b0, C_ANY},
    '{ROW_ITEM,  REG_COUNT, 64'd0, 34'd0, 1'b1, C_RANGE}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [STAT_W-1:0]      m_tuser;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [APB_AW-1:0]      paddr    = '0;
  logic [APB_DW-1:0]      pwdata   = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  // Shadow of the register file, updated at each register write transfer
  logic [COMP_W-1:0] cfg_count;
  logic [WID_W-1:0]  cfg_width  [MAX_COMPONENTS];
  logic [COEF_W-1:0] cfg_coeffs [MAX_COMPONENTS];
  logic [TOT_W-1:0]  cfg_total;

  coord_t pending_coords [$];
  int     mismatches = 0;
  int     src_idle_pct = 0;
  int     sink_idle_pct = 0;

  coefficient_index_to_block_coords_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  // Generous ceiling: several times the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Work out where a flat index lands under the shadow setting
  function automatic coord_t locate_coeff(input logic [IDX_W-1:0] idx);
    longint unsigned rest, rowsz, row;
    int              used, k;
    bit              hit;
    coord_t          res;
    res  = '0;
    rest = idx;
    k    = 0;
    hit  = 1'b0;
    used = (cfg_count > MAX_COMPONENTS) ? MAX_COMPONENTS : int'(cfg_count);
    if (rest >= cfg_total) begin
      res.status = STATUS_RANGE;
      return res;
    end
    // peel off whole components until the rest falls inside one
    while (!hit && k < used) begin
      if (rest < cfg_coeffs[k]) begin
        hit = 1'b1;
      end else begin
        rest -= cfg_coeffs[k];
        k++;
      end
    end
    res.status = STATUS_SIZE;
    if (!hit) return res;
    if (cfg_width[k] == 0 || cfg_width[k] > MAX_WIDTH) return res;
    rowsz = longint'(cfg_width[k]) * BLOCK_COEFFS;
    row   = rest / rowsz;
    if (row > (1 << ROW_W) - 1) return res;
    res.status    = STATUS_OK;
    res.component = COMP_W'(k);
    res.row       = ROW_W'(row);
    res.col       = ROW_W'((rest % rowsz) / BLOCK_COEFFS);
    res.pos       = POS_W'(rest % BLOCK_COEFFS);
    return res;
  endfunction

  // Register write: setup cycle, then access cycle; mirror the masking into the shadow.
  // The bus goes idle before the next write may start.
  task automatic apb_write(input reg_idx_t regno, input logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(regno) << REG_SHIFT;
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (regno)
      REG_COUNT:    cfg_count     = v[COMP_W-1:0];
      REG_WIDTH_0:  cfg_width[0]  = v[WID_W-1:0];
      REG_WIDTH_1:  cfg_width[1]  = v[WID_W-1:0];
      REG_WIDTH_2:  cfg_width[2]  = v[WID_W-1:0];
      REG_COEFFS_0: cfg_coeffs[0] = v[COEF_W-1:0];
      REG_COEFFS_1: cfg_coeffs[1] = v[COEF_W-1:0];
      REG_COEFFS_2: cfg_coeffs[2] = v[COEF_W-1:0];
      REG_TOTAL:    cfg_total     = v[TOT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid and hold until every result in flight has come back. Every index yields
  // exactly one result, so an empty store means the pipe is empty.
  task automatic drain_pipe();
    s_tvalid <= 1'b0;
    while (pending_coords.size() != 0) @(negedge clk);
  endtask

  // Offer one index, with random idle cycles ahead of it; record the expectation at the
  // transfer. Entered and left at a falling edge.
  task automatic send_index(input logic [IDX_W-1:0] idx, input coord_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - IDX_W){1'b0}}, idx};
    do @(posedge clk); while (!s_tready);
    pending_coords.push_back(want);
    @(negedge clk);
  endtask

  // Load a fresh image geometry into all eight registers
  task automatic choose_setting(input setting_t mode);
    logic [63:0]     w [MAX_COMPONENTS];
    logic [63:0]     cf [MAX_COMPONENTS];
    logic [63:0]     cnt_val, tot_val;
    longint unsigned sum;
    sum     = 0;
    cnt_val = $urandom_range(1, 3);
    if (mode == SET_EXTREME) cnt_val = MAX_COMPONENTS;
    if (mode == SET_BROKEN)  cnt_val = {$urandom, $urandom};
    for (int k = 0; k < MAX_COMPONENTS; k++) begin
      case (mode)
        SET_SMALL: begin
          w[k]  = $urandom_range(1, 4);
          cf[k] = w[k] * $urandom_range(1, 4) * BLOCK_COEFFS;
        end
        SET_WIDE: begin
          w[k]  = $urandom_range(1, MAX_WIDTH);
          cf[k] = w[k] * $urandom_range(1, MAX_WIDTH) * BLOCK_COEFFS;
        end
        SET_EXTREME: begin
          w[k]  = MAX_WIDTH;
          cf[k] = 64'h1_0000_0000;
        end
        default: begin
          // any width, counts either arbitrary or near or beyond the row limit
          w[k] = $urandom_range(0, (1 << WID_W) - 1);
          if ($urandom_range(0, 1)) cf[k] = {$urandom_range(0, 1), $urandom};
          else cf[k] = w[k] * $urandom_range(8000, 9000) * BLOCK_COEFFS;
        end
      endcase
      if (k < int'(cnt_val[COMP_W-1:0])) sum += cf[k];
    end
    tot_val = sum;
    if (mode == SET_BROKEN) begin
      case ($urandom_range(0, 2))
        0:       tot_val = {$urandom_range(0, 3), $urandom};
        1:       tot_val = sum + $urandom_range(1, 200);
        default: tot_val = sum;
      endcase
    end
    apb_write(REG_COUNT, cnt_val);
    for (int k = 0; k < MAX_COMPONENTS; k++) begin
      apb_write(reg_idx_t'(REG_WIDTH_0 + k), w[k]);
      apb_write(reg_idx_t'(REG_COEFFS_0 + k), cf[k]);
    end
    apb_write(REG_TOTAL, tot_val);
  endtask

  // Mostly indices inside the image, with a share at component seams, at the total
  // and anywhere in the 34-bit range.
  function automatic logic [IDX_W-1:0] pick_index();
    longint unsigned r64, seam;
    int              k;
    seam = 0;
    case ($urandom_range(0, 15))
      0: r64 = {$urandom, $urandom};
      1: r64 = cfg_total + $urandom_range(0, 2);
      2, 3: begin
        k = $urandom_range(0, MAX_COMPONENTS - 1);
        for (int i = 0; i <= k; i++) seam += cfg_coeffs[i];
        r64 = seam + $urandom_range(0, 3) - 2;
      end
      default: begin
        r64 = {$urandom, $urandom};
        if (cfg_total != 0) r64 = r64 % cfg_total;
      end
    endcase
    return r64[IDX_W-1:0];
  endfunction

  // Receiver: stall at random, decided at each falling edge
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Result checker: compare each transfer field by field with the oldest expectation
  always @(posedge clk) begin
    coord_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_coords.size() == 0) begin
        flag_mismatch($sformatf("result with nothing expected, tdata %h tuser %0d",
                                m_tdata, m_tuser));
      end else begin
        want = pending_coords.pop_front();
        if (m_tuser !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
        if (m_tdata[1:0] !== want.component)
          flag_mismatch($sformatf("component %0d, want %0d", m_tdata[1:0], want.component));
        if (m_tdata[14:2] !== want.row)
          flag_mismatch($sformatf("block_row %0d, want %0d", m_tdata[14:2], want.row));
        if (m_tdata[27:15] !== want.col)
          flag_mismatch($sformatf("block_col %0d, want %0d", m_tdata[27:15], want.col));
        if (m_tdata[33:28] !== want.pos)
          flag_mismatch($sformatf("coeff_pos %0d, want %0d", m_tdata[33:28], want.pos));
      end
    end
  end

  initial begin
    // shadow starts at the reset values
    cfg_count = RST_COUNT;
    cfg_total = RST_TOTAL;
    for (int k = 0; k < MAX_COMPONENTS; k++) begin
      cfg_width[k]  = RST_WIDTH;
      cfg_coeffs[k] = RST_COEFFS;
    end

    // hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part under light sender idling and heavy receiver back-pressure
    src_idle_pct  = 15;
    sink_idle_pct = 73;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        drain_pipe();
        apb_write(DIRECTED[i].regno, DIRECTED[i].value);
      end else begin
        send_index(DIRECTED[i].index,
                   DIRECTED[i].typed ? DIRECTED[i].want : locate_coeff(DIRECTED[i].index));
      end
    end

    // random part: three idling regimes, four geometries each including the largest
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct  = (phase == 0) ? 15 : (phase == 1) ? 73 : 0;
      sink_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 15 : 0;
      for (int s = 0; s < 4; s++) begin
        drain_pipe();
        choose_setting(setting_t'(s));
        repeat (75) begin
          logic [IDX_W-1:0] idx;
          idx = pick_index();
          send_index(idx, locate_coeff(idx));
        end
      end
    end

    // let the pipe empty, then watch a little longer for stray transfers
    drain_pipe();
    repeat (25) @(negedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

FILE: coefficient_index_to_block_coords_core.f
sv/cibc_pkg.sv
sv/cibc_cfg.sv
sv/cibc_seek.sv
sv/cibc_div.sv
sv/coefficient_index_to_block_coords_core.sv
sv/cibc_checker.sv
dv/testbench.sv
